[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the color reading to LED drive block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[sv/crgb_pkg.sv]
// Package with the types, constants and arithmetic helpers of the LED drive pipeline.
`default_nettype none

package crgb_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [15:0] COUNT_MASK = 16'((32'd1 << COUNT_BITS) - 32'd1);
    localparam int NUM_STAGES = 8;

    localparam logic [2:0] REG_INTEG_SELECT = 3'd0;
    localparam logic [2:0] REG_DARK_DIVISOR = 3'd1;
    localparam logic [2:0] REG_RED_OFFSET   = 3'd2;
    localparam logic [2:0] REG_GREEN_OFFSET = 3'd3;
    localparam logic [2:0] REG_BLUE_OFFSET  = 3'd4;

    typedef enum logic [1:0] {
        WIN_RED,
        WIN_GREEN,
        WIN_BLUE
    } t_win;

    typedef struct packed {
        logic [2:0] integ_select;
        logic [7:0] dark_divisor;
        logic [7:0] red_offset;
        logic [7:0] green_offset;
        logic [7:0] blue_offset;
    } t_cfg;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] full_scale;
        logic [23:0] dark_prod;
        logic        dark;
        logic [23:0] bright_rem;
        logic        bright_sat;
        logic [7:0]  bright_q;
        logic [7:0]  bright;
        t_win        winner;
        logic [15:0] top;
        logic [15:0] other1;
        logic [15:0] other2;
        logic [23:0] rem1;
        logic [23:0] rem2;
        logic [7:0]  q1;
        logic [7:0]  q2;
        logic [7:0]  lvl_red;
        logic [7:0]  lvl_green;
        logic [7:0]  lvl_blue;
        logic [15:0] mul_red;
        logic [15:0] mul_green;
        logic [15:0] mul_blue;
        logic [7:0]  drv_red;
        logic [7:0]  drv_green;
        logic [7:0]  drv_blue;
    } t_stage;

    // Full scale for an integration time code, saturated at the count range.
    function automatic logic [15:0] full_scale(input logic [2:0] sel);
        logic [15:0] fs;
        case (sel)
            3'd0:    fs = 16'd1024;
            3'd1:    fs = 16'd10240;
            3'd2:    fs = 16'd44032;
            default: fs = 16'd65535;
        endcase
        return (fs > COUNT_MASK) ? COUNT_MASK : fs;
    endfunction

    // Four restoring division steps; upper selects quotient bits 7..4, else 3..0.
    // Result is {quotient nibble, remainder}.
    function automatic logic [27:0] div4(input logic [23:0] rem_in,
                                         input logic [15:0] dvs,
                                         input logic        upper);
        logic [23:0] rem;
        logic [23:0] sh;
        logic [3:0]  q;
        rem = rem_in;
        q   = '0;
        for (int j = 3; j >= 0; j--) begin
            sh = 24'(dvs) << (j + (upper ? 4 : 0));
            if (rem >= sh) begin
                rem  = rem - sh;
                q[j] = 1'b1;
            end
        end
        return {q, rem};
    endfunction

    // Drive value 255 - floor(m / 255) for m up to 255 * 255.
    function automatic logic [7:0] to_drive(input logic [15:0] m);
        logic [16:0] t;
        t = 17'(m) + 17'd1 + 17'(m[15:8]);
        return 8'd255 - t[15:8];
    endfunction

endpackage

`default_nettype wire

[sv/crgb_regs.sv]
// Configuration register file with its reset values.
`default_nettype none

module crgb_regs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data,
    output crgb_pkg::t_cfg        o_cfg
);

    crgb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.integ_select <= 3'd4;
            r_cfg.dark_divisor <= 8'd10;
            r_cfg.red_offset   <= 8'd0;
            r_cfg.green_offset <= 8'd0;
            r_cfg.blue_offset  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crgb_pkg::REG_INTEG_SELECT: r_cfg.integ_select <= i_cfg_data[2:0];
                crgb_pkg::REG_DARK_DIVISOR: r_cfg.dark_divisor <= i_cfg_data;
                crgb_pkg::REG_RED_OFFSET:   r_cfg.red_offset   <= i_cfg_data;
                crgb_pkg::REG_GREEN_OFFSET: r_cfg.green_offset <= i_cfg_data;
                crgb_pkg::REG_BLUE_OFFSET:  r_cfg.blue_offset  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/color_reading_to_rgb_led_drive.sv]
// Top level: eight-stage pipeline from a color sensor reading to RGB LED drive values.
// An accepted input beat is registered in stage 1 and moves on through stages 2 to 8.
// Throughput is one beat per cycle while the output does not stall; every stage holds one
// reading and the eight-bit divisions are split into four restoring steps per stage.
// Reset (synchronous, active low) empties the pipeline and restores the registers.
`default_nettype none
`include "assert_macros.svh"

module color_reading_to_rgb_led_drive (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_red_count,
    input  wire logic [15:0] i_green_count,
    input  wire logic [15:0] i_blue_count,
    input  wire logic [15:0] i_clear_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red_drive,
    output logic [7:0]       o_green_drive,
    output logic [7:0]       o_blue_drive,
    output logic             o_too_dark
);

    localparam int NS = crgb_pkg::NUM_STAGES;

    crgb_pkg::t_cfg   cfg;
    crgb_pkg::t_stage r_s [1:NS];
    crgb_pkg::t_stage n_s [1:NS];
    logic             r_v [1:NS];
    logic             en  [1:NS+1];

    crgb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A stage may load when it is empty or when its contents move on in the
    // same cycle, so bubbles close up and a stall at the output backs up
    // only as far as the pipeline is full.
    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[1];

    always_comb begin
        logic [15:0] r, g, b, c;
        logic [7:0]  dv;
        logic [27:0] d0, d1;
        // Each stage starts from the fields of the stage before it, so values
        // that a stage does not touch travel along with the reading.
        n_s[1] = '0;
        for (int k = 2; k <= NS; k++) begin
            n_s[k] = r_s[k-1];
        end

        // Stage 1: mask the counts, look up the full scale, form the dark test
        // product and the scaled clear count, and pick the strongest channel.
        r  = i_red_count   & crgb_pkg::COUNT_MASK;
        g  = i_green_count & crgb_pkg::COUNT_MASK;
        b  = i_blue_count  & crgb_pkg::COUNT_MASK;
        c  = i_clear_count & crgb_pkg::COUNT_MASK;
        dv = (cfg.dark_divisor == 8'd0) ? 8'd1 : cfg.dark_divisor;
        n_s[1].red        = r;
        n_s[1].green      = g;
        n_s[1].blue       = b;
        n_s[1].full_scale = crgb_pkg::full_scale(cfg.integ_select);
        // The reading is dark when c < floor(fs / d), that is when c * d + d <= fs.
        n_s[1].dark_prod  = 24'(c) * 24'(dv) + 24'(dv);
        n_s[1].bright_rem = {c, 8'd0} - 24'(c);
        if (r >= b && r >= g) begin
            n_s[1].winner = crgb_pkg::WIN_RED;
            n_s[1].top    = r;
            n_s[1].other1 = g;
            n_s[1].other2 = b;
        end else if (g >= b && g >= r) begin
            n_s[1].winner = crgb_pkg::WIN_GREEN;
            n_s[1].top    = g;
            n_s[1].other1 = r;
            n_s[1].other2 = b;
        end else begin
            n_s[1].winner = crgb_pkg::WIN_BLUE;
            n_s[1].top    = b;
            n_s[1].other1 = r;
            n_s[1].other2 = g;
        end

        // Stage 2: dark decision, saturation check and upper quotient bits of
        // the brightness c * 255 / fs.
        n_s[2].dark       = r_s[1].dark_prod <= 24'(r_s[1].full_scale);
        n_s[2].bright_sat = r_s[1].bright_rem[23:8] >= r_s[1].full_scale;
        d0 = crgb_pkg::div4(r_s[1].bright_rem, r_s[1].full_scale, 1'b1);
        n_s[2].bright_q   = {d0[27:24], 4'd0};
        n_s[2].bright_rem = d0[23:0];

        // Stage 3: lower quotient bits; a saturated quotient becomes 255.
        d0 = crgb_pkg::div4(r_s[2].bright_rem, r_s[2].full_scale, 1'b0);
        n_s[3].bright_rem = d0[23:0];
        n_s[3].bright     = r_s[2].bright_sat ? 8'hFF : {r_s[2].bright_q[7:4], d0[27:24]};

        // Stage 4: the two weaker channels times the brightness.
        n_s[4].rem1 = 24'(r_s[3].other1) * 24'(r_s[3].bright);
        n_s[4].rem2 = 24'(r_s[3].other2) * 24'(r_s[3].bright);

        // Stage 5: upper quotient bits of both shares over the strongest count.
        d0 = crgb_pkg::div4(r_s[4].rem1, r_s[4].top, 1'b1);
        d1 = crgb_pkg::div4(r_s[4].rem2, r_s[4].top, 1'b1);
        n_s[5].q1   = {d0[27:24], 4'd0};
        n_s[5].q2   = {d1[27:24], 4'd0};
        n_s[5].rem1 = d0[23:0];
        n_s[5].rem2 = d1[23:0];

        // Stage 6: lower quotient bits, then route the levels to their colors.
        // When the strongest count is zero both shares are zero.
        d0 = crgb_pkg::div4(r_s[5].rem1, r_s[5].top, 1'b0);
        d1 = crgb_pkg::div4(r_s[5].rem2, r_s[5].top, 1'b0);
        n_s[6].q1 = (r_s[5].top == 16'd0) ? 8'd0 : {r_s[5].q1[7:4], d0[27:24]};
        n_s[6].q2 = (r_s[5].top == 16'd0) ? 8'd0 : {r_s[5].q2[7:4], d1[27:24]};
        n_s[6].rem1 = d0[23:0];
        n_s[6].rem2 = d1[23:0];
        case (r_s[5].winner)
            crgb_pkg::WIN_RED: begin
                n_s[6].lvl_red   = r_s[5].bright;
                n_s[6].lvl_green = n_s[6].q1;
                n_s[6].lvl_blue  = n_s[6].q2;
            end
            crgb_pkg::WIN_GREEN: begin
                n_s[6].lvl_red   = n_s[6].q1;
                n_s[6].lvl_green = r_s[5].bright;
                n_s[6].lvl_blue  = n_s[6].q2;
            end
            default: begin
                n_s[6].lvl_red   = n_s[6].q1;
                n_s[6].lvl_green = n_s[6].q2;
                n_s[6].lvl_blue  = r_s[5].bright;
            end
        endcase

        // Stage 7: each level times the span between off and the offset.
        n_s[7].mul_red   = 16'(r_s[6].lvl_red)   * 16'(8'd255 - cfg.red_offset);
        n_s[7].mul_green = 16'(r_s[6].lvl_green) * 16'(8'd255 - cfg.green_offset);
        n_s[7].mul_blue  = 16'(r_s[6].lvl_blue)  * 16'(8'd255 - cfg.blue_offset);

        // Stage 8: divide by 255 and invert; a dark reading turns all off.
        n_s[8].drv_red   = r_s[7].dark ? 8'hFF : crgb_pkg::to_drive(r_s[7].mul_red);
        n_s[8].drv_green = r_s[7].dark ? 8'hFF : crgb_pkg::to_drive(r_s[7].mul_green);
        n_s[8].drv_blue  = r_s[7].dark ? 8'hFF : crgb_pkg::to_drive(r_s[7].mul_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Payload registers carry no reset; a stage loads whenever it may.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s[1] <= n_s[1];
        end
        for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_valid       = r_v[NS];
    assign o_red_drive   = r_s[NS].drv_red;
    assign o_green_drive = r_s[NS].drv_green;
    assign o_blue_drive  = r_s[NS].drv_blue;
    assign o_too_dark    = r_s[NS].dark;

    `ASSERT_IMPL(a_dark_off, i_clk, i_rst_n, o_valid && o_too_dark,
        o_red_drive == 8'hFF && o_green_drive == 8'hFF && o_blue_drive == 8'hFF)
    `ASSERT_IMPL(a_empty_out_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_v[1])

endmodule

`default_nettype wire
